// ----- rtl/dda_pkg.sv -----
// Shared types and constants for the DDA line rasterizer.
package dda_pkg;

  // Fixed-point formats.
  localparam int COORD_BITS      = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int MINOR_BITS      = 32;
  localparam int SLOPE_BITS      = 20;
  localparam int MINOR_SHIFT     = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int MAJ_PIX_BITS    = COORD_BITS - 1 - COORD_FRAC_BITS;
  localparam int MIN_PIX_BITS    = MINOR_BITS - 1 - SLOPE_FRAC_BITS;
  localparam int MAG_BITS        = COORD_BITS;

  // Output and screen sizes.
  localparam int PIX_BITS    = 11;
  localparam int SCREEN_BITS = 12;
  localparam int SCREEN_MAX  = 2048;

  // Slope divider: one quotient bit per cycle.
  localparam int DIV_STEPS    = SLOPE_FRAC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Request codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic                       is_tick;
    logic                       x_is_major;
    logic [COORD_BITS-1:0]      major_start;
    logic [COORD_BITS-1:0]      major_limit;
    logic [COORD_BITS-1:0]      minor_start;
    logic [MAG_BITS-1:0]        dmin_mag;
    logic [MAG_BITS-1:0]        dmaj_mag;
    logic                       slope_neg;
    logic                       dmaj_zero;
  } queue_entry_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic         empty;
    queue_entry_t head;
  } queue_status_t;

  // Divider request and response.
  typedef struct packed {
    logic                start;
    logic [MAG_BITS-1:0] dividend;
    logic [MAG_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quotient;
  } div_rsp_t;

  // Screen size as seen by the back.
  typedef struct packed {
    logic [SCREEN_BITS-1:0] width;
    logic [SCREEN_BITS-1:0] height;
  } screen_t;

  // Back sequencer states.
  typedef enum logic {
    BK_RUN,
    BK_DIV
  } bk_state_t;

endpackage

// ----- rtl/dda_front.sv -----
// Front: accepts requests and classifies segments into queue entries.
module dda_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic signed [dda_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [dda_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [dda_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [dda_pkg::COORD_BITS-1:0] end_y,
  input  logic                              queue_full,
  output logic                              push,
  output dda_pkg::queue_entry_t             entry
);
  import dda_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] neg_dx;
  logic signed [COORD_BITS:0] neg_dy;
  logic [MAG_BITS-1:0]        adx;
  logic [MAG_BITS-1:0]        ady;
  logic                       x_major;
  logic signed [COORD_BITS-1:0] smaj;
  logic signed [COORD_BITS-1:0] emaj;
  logic signed [COORD_BITS-1:0] smin;
  logic signed [COORD_BITS-1:0] emin;

  // The queue refuses requests only when it is full.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Differences and their magnitudes; the magnitude always fits the coordinate width.
  always_comb begin
    dx     = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
    dy     = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
    neg_dx = -dx;
    neg_dy = -dy;
    adx    = dx[COORD_BITS] ? neg_dx[MAG_BITS-1:0] : dx[MAG_BITS-1:0];
    ady    = dy[COORD_BITS] ? neg_dy[MAG_BITS-1:0] : dy[MAG_BITS-1:0];
    x_major = adx > ady;
  end

  // Pick the major axis; on a tie y is major.
  always_comb begin
    if (x_major) begin
      smaj = start_x;
      emaj = end_x;
      smin = start_y;
      emin = end_y;
    end else begin
      smaj = start_y;
      emaj = end_y;
      smin = start_x;
      emin = end_x;
    end
  end

  // Build the entry; the walk starts at the endpoint with the smaller major value.
  always_comb begin
    entry.is_tick    = (op == OP_TICK);
    entry.x_is_major = x_major;
    if (smaj < emaj) begin
      entry.major_start = smaj;
      entry.major_limit = emaj;
      entry.minor_start = smin;
    end else begin
      entry.major_start = emaj;
      entry.major_limit = smaj;
      entry.minor_start = emin;
    end
    if (x_major) begin
      entry.dmin_mag  = ady;
      entry.dmaj_mag  = adx;
      entry.slope_neg = dx[COORD_BITS] ^ dy[COORD_BITS];
      entry.dmaj_zero = (adx == '0);
    end else begin
      entry.dmin_mag  = adx;
      entry.dmaj_mag  = ady;
      entry.slope_neg = dx[COORD_BITS] ^ dy[COORD_BITS];
      entry.dmaj_zero = (ady == '0);
    end
  end

endmodule

// ----- rtl/dda_queue.sv -----
// Short request queue between the front and the back.
module dda_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dda_pkg::queue_entry_t  push_entry,
  input  logic                   pop,
  output logic                   full,
  output dda_pkg::queue_status_t status
);
  import dda_pkg::*;

  queue_entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full         = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.head  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/dda_div.sv -----
// Restoring divider that yields the slope magnitude one bit per cycle.
module dda_div (
  input  logic              clk,
  input  logic              rst,
  input  dda_pkg::div_req_t req,
  output dda_pkg::div_rsp_t rsp
);
  import dda_pkg::*;

  logic                    running;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [MAG_BITS:0]       rem;
  logic [MAG_BITS-1:0]     divisor;
  logic [DIV_STEPS-1:0]    quo;
  logic                    done;
  logic                    ge;
  logic [MAG_BITS:0]       rem_sub;

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // One trial subtraction per cycle; the remainder stays below the divisor.
  always_comb begin
    ge      = rem >= {1'b0, divisor};
    rem_sub = ge ? (rem - {1'b0, divisor}) : rem;
  end

  // Control: a run of one step per quotient bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == '0);
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CNT_BITS'(DIV_STEPS - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder starts at the unshifted minor magnitude and shifts up each step.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= {1'b0, req.dividend};
      divisor <= req.divisor;
      quo     <= '0;
    end else if (running) begin
      rem <= {rem_sub[MAG_BITS-1:0], 1'b0};
      quo <= {quo[DIV_STEPS-2:0], ge};
    end
  end

endmodule

// ----- rtl/dda_back.sv -----
// Back: loads segments through the divider and steps them one tick at a time.
module dda_back (
  input  logic                   clk,
  input  logic                   rst,
  input  dda_pkg::queue_status_t q_status,
  output logic                   pop,
  output dda_pkg::div_req_t      div_req,
  input  dda_pkg::div_rsp_t      div_rsp,
  input  dda_pkg::screen_t       screen,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   pixel_valid,
  output logic [dda_pkg::PIX_BITS-1:0] pixel_x,
  output logic [dda_pkg::PIX_BITS-1:0] pixel_y,
  output logic                   last
);
  import dda_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  logic                          busy;
  logic                          x_is_major;
  logic signed [COORD_BITS-1:0]  major_position;
  logic signed [COORD_BITS-1:0]  major_limit;
  logic signed [MINOR_BITS-1:0]  minor_position;
  logic signed [SLOPE_BITS-1:0]  step_slope;
  logic                          ld_slope_neg;
  logic                          ld_dmaj_zero;

  logic                          tick_fire;
  logic                          load_fire;
  logic [SCREEN_BITS-1:0]        wmaj;
  logic [SCREEN_BITS-1:0]        wmin;
  logic [MAJ_PIX_BITS-1:0]       maj_pix;
  logic [MIN_PIX_BITS-1:0]       min_pix;
  logic                          oob;
  logic signed [COORD_BITS:0]    major_next;
  logic                          seg_end;
  logic [SLOPE_BITS-1:0]         slope_mag;
  logic [SLOPE_BITS-1:0]         slope_neg_mag;
  logic [PIX_BITS-1:0]           px;
  logic [PIX_BITS-1:0]           py;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      BK_RUN: begin
        if (!q_status.empty && !q_status.head.is_tick) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // Sequencer outputs: pop a load into the divider, drop idle ticks, fire live ticks.
  always_comb begin
    pop       = 1'b0;
    load_fire = 1'b0;
    tick_fire = 1'b0;
    case (state)
      BK_RUN: begin
        if (!q_status.empty) begin
          if (!q_status.head.is_tick) begin
            pop       = 1'b1;
            load_fire = 1'b1;
          end else if (!busy) begin
            pop = 1'b1;
          end else if (!out_valid || !out_stall) begin
            pop       = 1'b1;
            tick_fire = 1'b1;
          end
        end
      end
      BK_DIV: begin
        pop = 1'b0;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = load_fire;
    div_req.dividend = q_status.head.dmin_mag;
    div_req.divisor  = q_status.head.dmaj_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Bounds check of the current point against the screen.
  always_comb begin
    wmaj    = x_is_major ? screen.width : screen.height;
    wmin    = x_is_major ? screen.height : screen.width;
    maj_pix = major_position[COORD_BITS-2:COORD_FRAC_BITS];
    min_pix = minor_position[MINOR_BITS-2:SLOPE_FRAC_BITS];
    oob     = major_position[COORD_BITS-1]
           || (SCREEN_BITS'(maj_pix) >= wmaj)
           || minor_position[MINOR_BITS-1]
           || (min_pix >= MIN_PIX_BITS'(wmin));
    px      = x_is_major ? PIX_BITS'(maj_pix) : PIX_BITS'(min_pix);
    py      = x_is_major ? PIX_BITS'(min_pix) : PIX_BITS'(maj_pix);
  end

  // One unit step along the major axis; the segment ends once it would pass the limit.
  always_comb begin
    major_next = (COORD_BITS+1)'(major_position)
               + (COORD_BITS+1)'(1 << COORD_FRAC_BITS);
    seg_end    = major_next > (COORD_BITS+1)'(major_limit);
  end

  // Signed slope from the divider's magnitude.
  always_comb begin
    slope_mag     = SLOPE_BITS'(div_rsp.quotient);
    slope_neg_mag = -slope_mag;
  end

  // Segment state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (state == BK_DIV && div_rsp.done) begin
      busy <= 1'b1;
    end else if (tick_fire && (oob || seg_end)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      x_is_major     <= q_status.head.x_is_major;
      major_position <= q_status.head.major_start;
      major_limit    <= q_status.head.major_limit;
      minor_position <= MINOR_BITS'($signed(q_status.head.minor_start)) <<< MINOR_SHIFT;
      ld_slope_neg   <= q_status.head.slope_neg;
      ld_dmaj_zero   <= q_status.head.dmaj_zero;
    end else if (tick_fire && !oob && !seg_end) begin
      major_position <= major_next[COORD_BITS-1:0];
      minor_position <= minor_position + MINOR_BITS'(step_slope);
    end
    if (state == BK_DIV && div_rsp.done) begin
      if (ld_dmaj_zero) begin
        step_slope <= '0;
      end else if (ld_slope_neg) begin
        step_slope <= slope_neg_mag;
      end else begin
        step_slope <= slope_mag;
      end
    end
  end

  // Output register holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      pixel_valid <= !oob;
      pixel_x     <= oob ? '0 : px;
      pixel_y     <= oob ? '0 : py;
      last        <= oob || seg_end;
    end
  end

endmodule

// ----- rtl/dda_line_rasterizer.sv -----
// Top level of the DDA line rasterizer: screen registers, front, queue, divider and back.
//
// Usage: requests arrive on in_valid/in_stall with op, start_x, start_y, end_x, end_y
// (signed Q12.4). A load request (op = 0) sets up a segment; a tick request (op = 1)
// produces at most one pixel result on out_valid/out_stall with pixel_valid, pixel_x,
// pixel_y and last. Ticks while no segment is active give no result.
// Requests pass through a 4-entry queue, so in_stall rises only when it is full.
// A tick that reaches the back yields its result in the output register in the next
// cycle, and ticks run at one per cycle while the output register drains. A load
// occupies the back until the slope divider, one quotient bit per cycle, is done.
// screen_width (index 0) and screen_height (index 1) are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle, and
// the block does not enforce this. Values above 2048 read as 2048. Reset empties the
// queue, ends any segment and sets the screen to 640 by 480. While out_stall is high
// the result stays in the output register; live ticks wait, new requests are queued.
module dda_line_rasterizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic signed [dda_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [dda_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [dda_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [dda_pkg::COORD_BITS-1:0] end_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  pixel_valid,
  output logic [dda_pkg::PIX_BITS-1:0]          pixel_x,
  output logic [dda_pkg::PIX_BITS-1:0]          pixel_y,
  output logic                                  last,
  input  logic                                  cfg_we,
  input  logic [dda_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [dda_pkg::SCREEN_BITS-1:0]       cfg_data
);
  import dda_pkg::*;

  screen_t                screen;
  logic [SCREEN_BITS-1:0] cfg_clamped;
  logic                   push;
  logic                   pop;
  logic                   queue_full;
  queue_entry_t           entry;
  queue_status_t          q_status;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Screen size registers, clamped to the largest screen.
  assign cfg_clamped = (cfg_data > SCREEN_BITS'(SCREEN_MAX)) ? SCREEN_BITS'(SCREEN_MAX)
                                                            : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen.width  <= SCREEN_BITS'(640);
      screen.height <= SCREEN_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen.width  <= cfg_clamped;
        CFG_SCREEN_HEIGHT: screen.height <= cfg_clamped;
        default: ;
      endcase
    end
  end

  dda_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .queue_full (queue_full),
    .push       (push),
    .entry      (entry)
  );

  dda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (queue_full),
    .status     (q_status)
  );

  dda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .pop         (pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .screen      (screen),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last        (last)
  );

endmodule
